// File: hw/rtl/ole_pkg.sv
// Package for the ordered list engine: sizes, operation and status codes,
// the sweep token carried along the cell chain, and the controller states.
// No dependencies.
package ole_pkg;

    localparam int CAPACITY    = 256;
    localparam int ENTRY_WIDTH = 32;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 8;
    localparam int ENTRY_O_W = 32;
    localparam int INDEX_O_W = 8;
    localparam int COUNT_O_W = 9;
    localparam int STATUS_W  = 2;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND       = 3'd0,
        OP_READ         = 3'd1,
        OP_FIND         = 3'd2,
        OP_REMOVE_AT    = 3'd3,
        OP_REMOVE_VALUE = 3'd4,
        OP_SIZE         = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_RANGE     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic                   active;
        op_t                    op;
        logic [ENTRY_WIDTH-1:0] word;
        logic [POS_W-1:0]       pos;
        logic [IDX_W-1:0]       idx;
        logic [COUNT_W-1:0]     count;
        logic                   hit;
        logic [IDX_W-1:0]       hit_idx;
        logic [ENTRY_WIDTH-1:0] rd_data;
    } ole_token_t;

    typedef struct packed {
        logic [ENTRY_O_W-1:0] entry_out;
        logic [INDEX_O_W-1:0] found_index;
        logic [COUNT_O_W-1:0] entry_count;
        status_t              status;
    } ole_result_t;

endpackage

// File: hw/rtl/ole_if.sv
// Request and response channel interfaces of the ordered list engine.
// Depends on ole_pkg for field widths.
interface ole_req_if;
    import ole_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [VALUE_W-1:0]   value;
    logic [POS_W-1:0]     position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface ole_rsp_if;
    import ole_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [ENTRY_O_W-1:0] entry_out;
    logic [INDEX_O_W-1:0] found_index;
    logic [COUNT_O_W-1:0] entry_count;
    logic [STATUS_W-1:0]  status;

    modport source (output valid, output entry_out, output found_index,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input entry_out, input found_index,
                    input entry_count, input status, output ready);
endinterface

// File: hw/rtl/ole_cell.sv
// One list cell: holds one entry and acts on the sweep token as it passes.
// Depends on ole_pkg.
module ole_cell
    import ole_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ole_token_t             tok_in,
    input  logic [ENTRY_WIDTH-1:0] right_entry,
    output ole_token_t             tok_out,
    output logic [ENTRY_WIDTH-1:0] entry
);

    logic [ENTRY_WIDTH-1:0] entry_reg;
    logic [ENTRY_WIDTH-1:0] entry_next;
    ole_token_t             tok_reg;
    ole_token_t             tok_next;
    logic                   active_reg;
    logic                   in_list;
    logic                   at_pos;
    logic                   at_end;
    logic                   match;

    assign in_list = CMP_W'(tok_in.idx) < CMP_W'(tok_in.count);
    assign at_pos  = CMP_W'(tok_in.idx) == CMP_W'(tok_in.pos);
    assign at_end  = CMP_W'(tok_in.idx) == CMP_W'(tok_in.count);
    assign match   = in_list && (entry_reg == tok_in.word);

    always_comb
    begin
        entry_next   = entry_reg;
        tok_next     = tok_in;
        tok_next.idx = tok_in.idx + 1'b1;
        if (tok_in.active)
        begin
            unique case (tok_in.op)
                OP_APPEND:
                begin
                    if (at_end)
                    begin
                        entry_next = tok_in.word;
                    end
                end
                OP_READ:
                begin
                    if (at_pos && in_list)
                    begin
                        tok_next.rd_data = entry_reg;
                    end
                end
                OP_FIND:
                begin
                    if (!tok_in.hit && match)
                    begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = tok_in.idx;
                    end
                end
                OP_REMOVE_AT:
                begin
                    if (at_pos && in_list)
                    begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = tok_in.idx;
                    end
                    if (tok_next.hit)
                    begin
                        entry_next = right_entry;
                    end
                end
                OP_REMOVE_VALUE:
                begin
                    if (!tok_in.hit && match)
                    begin
                        tok_next.hit     = 1'b1;
                        tok_next.hit_idx = tok_in.idx;
                    end
                    if (tok_next.hit)
                    begin
                        entry_next = right_entry;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tok_reg   <= tok_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= tok_in.active;
        end
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = active_reg;
    end

    assign entry = entry_reg;

endmodule

// File: hw/rtl/ole_ctrl.sv
// Controller: takes requests, launches the sweep token, keeps the entry count
// and forms the result from the returning token. Depends on ole_pkg, ole_if.
module ole_ctrl
    import ole_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    ole_req_if.sink    req,
    ole_rsp_if.source  rsp,
    output ole_token_t tok_launch,
    input  ole_token_t tok_done
);

    ctrl_state_t        state_reg;
    ctrl_state_t        state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    ole_result_t        out_reg;
    ole_result_t        out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    ole_result_t        pend_reg;
    ole_result_t        pend_next;
    ole_result_t        res;
    logic [COUNT_W-1:0] res_count;
    logic               pos_ok;
    logic               full;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        tok_launch         = '0;
        tok_launch.active  = req.valid && req.ready;
        tok_launch.op      = op_t'(req.operation);
        tok_launch.word    = ENTRY_WIDTH'(req.value);
        tok_launch.pos     = req.position;
        tok_launch.count   = count_reg;
    end

    assign pos_ok = CMP_W'(tok_done.pos) < CMP_W'(count_reg);
    assign full   = CMP_W'(count_reg) == CMP_W'(CAPACITY);

    always_comb
    begin
        res_count = count_reg;
        res       = '0;
        res.status = ST_OK;
        unique case (tok_done.op)
            OP_APPEND:
            begin
                if (full)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    res_count = count_reg + 1'b1;
                end
            end
            OP_READ:
            begin
                if (pos_ok)
                begin
                    res.entry_out = ENTRY_O_W'(tok_done.rd_data);
                end
                else
                begin
                    res.status = ST_RANGE;
                end
            end
            OP_FIND:
            begin
                if (tok_done.hit)
                begin
                    res.found_index = INDEX_O_W'(tok_done.hit_idx);
                end
                else
                begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_REMOVE_AT:
            begin
                if (tok_done.hit)
                begin
                    res.found_index = INDEX_O_W'(tok_done.hit_idx);
                    res_count       = count_reg - 1'b1;
                end
                else
                begin
                    res.status = ST_RANGE;
                end
            end
            OP_REMOVE_VALUE:
            begin
                if (tok_done.hit)
                begin
                    res.found_index = INDEX_O_W'(tok_done.hit_idx);
                    res_count       = count_reg - 1'b1;
                end
                else
                begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
        res.entry_count = COUNT_O_W'(res_count);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_next       = out_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (tok_done.active)
                begin
                    count_next = res_count;
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_next       = res;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        pend_next  = res;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (rsp.ready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.entry_out   = out_reg.entry_out;
    assign rsp.found_index = out_reg.found_index;
    assign rsp.entry_count = out_reg.entry_count;
    assign rsp.status      = out_reg.status;

endmodule

// File: hw/rtl/ordered_list_engine_unit.sv
// Ordered list engine: a dense list of up to CAPACITY words with append,
// read at index, find, remove at index, remove by value and size requests.
// Requests arrive on the req channel, one result per item leaves on rsp.
// Both channels use valid/ready; an item moves when both are high.
// Each entry lives in one cell of a chain. An accepted item launches a token
// that walks the chain one cell per cycle; each cell compares, reads, writes
// or shifts its entry as the token passes, removal pulling the right
// neighbor's entry forward.
// The token passes the register of every cell in turn and its result is then
// registered in the output register, whatever the operation; a new item is taken
// only once the token has returned and its result has moved to the output register.
// A finished result waits in the output register; the next item is accepted
// while it waits, and a second result is held back until the first is taken.
// Reset clears the entry count and the channel state; the list is empty and
// unwritten entries are never read.
// Depends on ole_pkg, ole_if, ole_cell and ole_ctrl.
module ordered_list_engine_unit
    import ole_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ole_req_if.sink   req,
    ole_rsp_if.source rsp
);

    ole_token_t             tok   [CAPACITY+1];
    logic [ENTRY_WIDTH-1:0] ent   [CAPACITY+1];

    assign ent[CAPACITY] = '0;

    ole_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .tok_launch (tok[0]),
        .tok_done   (tok[CAPACITY])
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ole_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .tok_in      (tok[i]),
            .right_entry (ent[i+1]),
            .tok_out     (tok[i+1]),
            .entry       (ent[i])
        );
    end

endmodule

// File: dv/ordered_list_engine_unit_test.sv
// Testbench for ordered_list_engine_unit: directed and random list requests, each result
// checked against an in-bench copy of the list. Depends on ole_pkg, ole_if and the RTL.
// Sender idles in random bursts, receiver stalls on its own pattern.
module ordered_list_engine_unit_test;
    import ole_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_LO  = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI  = 3'd7;
    localparam int unsigned     CYCLE_LIMIT  = 10_000_000;
    localparam int              MIXED_ITEMS  = 1000;
    localparam int              PRINT_LIMIT  = 50;

    logic clk;
    logic rst_n;

    ole_req_if req_ch ();
    ole_rsp_if rsp_ch ();

    ordered_list_engine_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [VALUE_W-1:0] list_words [CAPACITY];
    int                 list_count = 0;
    ole_result_t        pending_results [$];
    int                 mismatch_count = 0;
    int                 results_seen = 0;
    int unsigned        burst_left = 0;
    int unsigned        cycle_count = 0;

    logic [VALUE_W-1:0] word_pool [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                          32'h8000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                          32'h0000_00FF, 32'h7FFF_FFFF};

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int locate_word(logic [VALUE_W-1:0] word);
        for (int i = 0; i < list_count; i++)
        begin
            if (list_words[IDX_W'(i)] == word)
                return i;
        end
        return -1;
    endfunction

    function automatic void close_gap(int idx);
        for (int i = idx; i + 1 < list_count; i++)
            list_words[IDX_W'(i)] = list_words[IDX_W'(i + 1)];
        list_count--;
    endfunction

    function automatic ole_result_t apply_list_request(logic [OP_W-1:0] op,
                                                       logic [VALUE_W-1:0] word,
                                                       logic [POS_W-1:0] pos);
        ole_result_t r;
        int          idx;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_APPEND:
            begin
                if (list_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[IDX_W'(list_count)] = word;
                    list_count++;
                end
            end
            OP_READ:
            begin
                if (pos < list_count)
                    r.entry_out = list_words[pos];
                else
                    r.status = ST_RANGE;
            end
            OP_FIND:
            begin
                idx = locate_word(word);
                if (idx >= 0)
                    r.found_index = INDEX_O_W'(idx);
                else
                    r.status = ST_NOT_FOUND;
            end
            OP_REMOVE_AT:
            begin
                if (pos < list_count)
                begin
                    close_gap(int'(pos));
                    r.found_index = pos;
                end
                else
                    r.status = ST_RANGE;
            end
            OP_REMOVE_VALUE:
            begin
                idx = locate_word(word);
                if (idx >= 0)
                begin
                    close_gap(idx);
                    r.found_index = INDEX_O_W'(idx);
                end
                else
                    r.status = ST_NOT_FOUND;
            end
            default:
            begin
            end
        endcase
        r.entry_count = COUNT_O_W'(list_count);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t result %0d: %s got %0h expected %0h",
                     $time, results_seen, what, got, want);
    endtask

    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] word,
                                input logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                7:       gap = $urandom_range(20, 300);
                default: gap = $urandom_range(1, 8);
            endcase
        end
        burst_left--;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= word;
        req_ch.position  <= pos;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_list_request(op, word, pos));
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        int unsigned k;
        k = $urandom_range(0, 9);
        if (k < 3 && list_count > 0)
            return list_words[IDX_W'($urandom_range(0, list_count - 1))];
        else if (k < 8)
            return word_pool[3'($urandom_range(0, 7))];
        return $urandom();
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (list_count > 0 && $urandom_range(0, 9) < 8)
            return POS_W'($urandom_range(0, list_count - 1));
        return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [OP_W-1:0] choose_op(bit grow);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < (grow ? 45 : 10))
            return OP_APPEND;
        else if (r < (grow ? 65 : 30))
            return OP_READ;
        else if (r < (grow ? 80 : 45))
            return OP_FIND;
        else if (r < (grow ? 89 : 70))
            return OP_REMOVE_AT;
        else if (r < (grow ? 97 : 95))
            return OP_REMOVE_VALUE;
        else if (r < 98)
            return OP_SIZE;
        return $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    endfunction

    task automatic check_empty_list_requests();
        send_request(OP_SIZE, 32'h0, 8'd0);
        send_request(OP_READ, 32'h0, 8'd0);
        send_request(OP_READ, 32'h0, 8'd255);
        send_request(OP_FIND, 32'h0, 8'd0);
        send_request(OP_REMOVE_AT, 32'h0, 8'd0);
        send_request(OP_REMOVE_VALUE, 32'hFFFF_FFFF, 8'd255);
        send_request(OP_SPARE_LO, $urandom(), POS_W'($urandom_range(0, 255)));
        send_request(OP_SPARE_HI, $urandom(), POS_W'($urandom_range(0, 255)));
        send_request(OP_APPEND, 32'h0000_0000, 8'd0);
        send_request(OP_APPEND, 32'hFFFF_FFFF, 8'd255);
        send_request(OP_APPEND, 32'hA5A5_A5A5, 8'd0);
        send_request(OP_APPEND, 32'hFFFF_FFFF, 8'd0);
        send_request(OP_APPEND, 32'h0000_0000, 8'd0);
        send_request(OP_FIND, 32'hFFFF_FFFF, 8'd0);
        send_request(OP_FIND, 32'h0000_0000, 8'd0);
        send_request(OP_READ, 32'h0, 8'd0);
        send_request(OP_READ, 32'h0, 8'd4);
        send_request(OP_READ, 32'h0, 8'd5);
        send_request(OP_REMOVE_AT, 32'h0, 8'd2);
        send_request(OP_REMOVE_VALUE, 32'hFFFF_FFFF, 8'd0);
        send_request(OP_READ, 32'h0, 8'd1);
        send_request(OP_REMOVE_AT, 32'h0, 8'd2);
        send_request(OP_FIND, 32'hA5A5_A5A5, 8'd0);
        send_request(OP_REMOVE_AT, 32'h0, 8'd255);
        send_request(OP_SIZE, 32'h0, 8'd0);
    endtask

    task automatic check_fill_to_capacity();
        while (list_count < CAPACITY)
            send_request(OP_APPEND, pick_word(), POS_W'($urandom_range(0, 255)));
        send_request(OP_APPEND, $urandom(), 8'd0);
        send_request(OP_APPEND, 32'hFFFF_FFFF, 8'd255);
        send_request(OP_READ, 32'h0, 8'd255);
        send_request(OP_READ, 32'h0, 8'd0);
        send_request(OP_FIND, word_pool[1], 8'd0);
        send_request(OP_FIND, list_words[CAPACITY - 1], 8'd0);
        send_request(OP_REMOVE_AT, 32'h0, 8'd255);
        send_request(OP_APPEND, $urandom(), 8'd0);
        send_request(OP_APPEND, $urandom(), 8'd0);
        send_request(OP_REMOVE_VALUE, list_words[0], 8'd0);
        send_request(OP_SIZE, 32'h0, 8'd0);
    endtask

    task automatic check_mixed_traffic();
        int               target;
        logic [OP_W-1:0]  op;
        target = 0;
        for (int n = 0; n < MIXED_ITEMS; n++)
        begin
            if (n % 80 == 0)
                target = ($urandom_range(0, 3) == 0) ? CAPACITY : $urandom_range(0, CAPACITY);
            op = choose_op(list_count < target);
            send_request(op, pick_word(), pick_position());
        end
    endtask

    task automatic check_drain_to_empty();
        while (list_count > 0)
        begin
            if ($urandom_range(0, 1))
                send_request(OP_REMOVE_AT, $urandom(), pick_position());
            else
                send_request(OP_REMOVE_VALUE,
                             list_words[IDX_W'($urandom_range(0, list_count - 1))],
                             POS_W'($urandom_range(0, 255)));
        end
        send_request(OP_REMOVE_AT, 32'h0, 8'd0);
        send_request(OP_FIND, pick_word(), 8'd0);
        send_request(OP_SIZE, 32'h0, 8'd0);
    endtask

    always @(posedge clk)
    begin
        ole_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, status", 32'(rsp_ch.status), 32'h0);
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.entry_out !== want.entry_out)
                    report_mismatch("entry_out", rsp_ch.entry_out, want.entry_out);
                if (rsp_ch.found_index !== want.found_index)
                    report_mismatch("found_index", 32'(rsp_ch.found_index),
                                    32'(want.found_index));
                if (rsp_ch.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 32'(rsp_ch.entry_count),
                                    32'(want.entry_count));
                if (rsp_ch.status !== want.status)
                    report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
            end
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned span;
        rsp_ch.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 7);
            span = (mode == 7) ? $urandom_range(10, 350) : $urandom_range(20, 600);
            for (int k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (mode)
                    0, 1, 2: rsp_ch.ready <= 1'b1;
                    3, 4, 5: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    6:       rsp_ch.ready <= (k % 4 != 3);
                    default: rsp_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** ordered_list_engine_unit: FAILED **");
        $finish;
    end

    initial
    begin
        req_ch.valid     = 1'b0;
        req_ch.operation = '0;
        req_ch.value     = '0;
        req_ch.position  = '0;
        rst_n            = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        check_empty_list_requests();
        check_fill_to_capacity();
        check_mixed_traffic();
        check_drain_to_empty();

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 32) @(posedge clk);

        if (mismatch_count == 0)
            $display("** ordered_list_engine_unit: PASSED **");
        else
            $display("** ordered_list_engine_unit: FAILED **");
        $finish;
    end

endmodule
